// ===== src/tboa_pkg.sv =====
// Shared types and constants for the two-box ownership arbiter.
`timescale 1ns / 1ps

package tboa_pkg;

   localparam int unsigned EPOCH_WIDTH_DEFAULT = 32;

   localparam logic [7:0] OWNER_UNOWNED = 8'd255;
   localparam logic [7:0] OWNER_BOX0    = 8'd0;
   localparam logic [7:0] OWNER_BOX1    = 8'd1;

   typedef enum logic [1:0] {
      CMD_REMOTE_UPDATE = 2'd0,
      CMD_PACKET_EVENT  = 2'd1,
      CMD_LOCAL_CLAIM   = 2'd2,
      CMD_UNUSED        = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      MODE_UNOWNED = 2'd0,
      MODE_LOCAL   = 2'd1,
      MODE_REMOTE  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      VERDICT_NOOP          = 3'd0,
      VERDICT_APPLY_REMOTE  = 3'd1,
      VERDICT_KEEP_LOCAL    = 3'd2,
      VERDICT_EMIT_UPDATE   = 3'd3,
      VERDICT_PROCESS_LOCAL = 3'd4,
      VERDICT_FORWARD       = 3'd5,
      VERDICT_MIGRATE       = 3'd6
   } verdict_type;

   typedef enum logic [3:0] {
      CAUSE_INVALID       = 4'd0,
      CAUSE_NEWER_EPOCH   = 4'd1,
      CAUSE_STALE_EPOCH   = 4'd2,
      CAUSE_HIGHER_GEN    = 4'd3,
      CAUSE_STALE_GEN     = 4'd4,
      CAUSE_DUPLICATE     = 4'd5,
      CAUSE_TIE_WIN       = 4'd6,
      CAUSE_TIE_KEEP      = 4'd7,
      CAUSE_REFRESH       = 4'd8,
      CAUSE_CLAIM         = 4'd9,
      CAUSE_HIT           = 4'd10,
      CAUSE_MIGRATE       = 4'd11,
      CAUSE_MISROUTE      = 4'd12,
      CAUSE_UNOWNED_CLAIM = 4'd13
   } cause_type;

   typedef enum logic [1:0] {
      CSR_MY_BOX           = 2'd0,
      CSR_MIGRATE_LIMIT    = 2'd1,
      CSR_MY_SUBSCRIBER    = 2'd2,
      CSR_EXPECTED_VERSION = 2'd3
   } csr_index_type;

   localparam logic [7:0]  VERSION_RESET = 8'd1;

   // Owner codes that a remote update may legally carry.
   function automatic logic owner_ok(input logic [15:0] code);
      owner_ok = (code == 16'(OWNER_BOX0)) || (code == 16'(OWNER_BOX1)) ||
                 (code == 16'(OWNER_UNOWNED));
   endfunction

endpackage

// ===== src/two_box_ownership_arbiter_unit.sv =====
// Top level of the two-box ownership arbiter: request register, decision logic, response register.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake            Payload
//  req_      in         req_valid/req_ready  command and remote update fields, event time
//  rsp_      out        rsp_valid/rsp_ready  status, verdict, cause, emitted update
//  csr_      in         csr_valid/csr_ready  csr_index (2 bits), csr_data (32 bits)
//
// An accepted request waits in the request register; the decision logic then writes the record
// and the response register in the same edge.
// One request per cycle is sustained while rsp_ready is high; the record update is a one-register loop.
// Synchronous reset empties both registers and restores the record and the settings.
// A stalled response holds the request register, which then holds req_ready low.
module two_box_ownership_arbiter_unit #(
   parameter int unsigned EPOCH_WIDTH = tboa_pkg::EPOCH_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_command,
   input  logic [7:0]             req_in_version,
   input  logic [31:0]            req_in_subscriber,
   input  logic [EPOCH_WIDTH-1:0] req_in_epoch,
   input  logic [31:0]            req_in_gen,
   input  logic [15:0]            req_in_owner_wide,
   input  logic [7:0]             req_in_owner_byte,
   input  logic [63:0]            req_in_activation,
   input  logic [63:0]            req_in_stamp,
   input  logic [31:0]            req_in_policy,
   input  logic [63:0]            req_event_time,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_status_code,
   output logic [2:0]             rsp_verdict,
   output logic [3:0]             rsp_cause,
   output logic                   rsp_emit_valid,
   output logic [7:0]             rsp_out_owner,
   output logic [31:0]            rsp_out_gen,
   output logic [EPOCH_WIDTH-1:0] rsp_out_epoch,
   output logic [63:0]            rsp_out_activation,
   output logic [31:0]            rsp_out_policy,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data
);

   // Settings.
   logic                   my_box_ff;
   logic [31:0]            migrate_limit_ff;
   logic [31:0]            my_subscriber_ff;
   logic [7:0]             expected_version_ff;

   // Ownership record.
   logic [7:0]             cur_owner_ff,      cur_owner_in;
   tboa_pkg::mode_type     own_mode_ff,       own_mode_in;
   logic [EPOCH_WIDTH-1:0] cur_epoch_ff,      cur_epoch_in;
   logic [31:0]            cur_gen_ff,        cur_gen_in;
   logic [63:0]            cur_activation_ff, cur_activation_in;
   logic [63:0]            cur_last_seen_ff,  cur_last_seen_in;
   logic [31:0]            cur_policy_ff,     cur_policy_in;
   logic [31:0]            misroute_count_ff, misroute_count_in;

   // Request register.
   logic                   req_full_ff;
   tboa_pkg::command_type  command_ff;
   logic [7:0]             version_ff;
   logic [31:0]            subscriber_ff;
   logic [EPOCH_WIDTH-1:0] epoch_ff;
   logic [31:0]            gen_ff;
   logic [15:0]            owner_wide_ff;
   logic [7:0]             owner_byte_ff;
   logic [63:0]            activation_ff;
   logic [63:0]            stamp_ff;
   logic [31:0]            policy_ff;
   logic [63:0]            event_time_ff;

   // Response register.
   logic                   rsp_full_ff;
   logic                   status_ff,         status_in;
   tboa_pkg::verdict_type  verdict_ff,        verdict_in;
   tboa_pkg::cause_type    cause_ff,          cause_in;
   logic                   emit_ff,           emit_in;
   logic [7:0]             out_owner_ff,      out_owner_in;
   logic [31:0]            out_gen_ff,        out_gen_in;
   logic [EPOCH_WIDTH-1:0] out_epoch_ff,      out_epoch_in;
   logic [63:0]            out_activation_ff, out_activation_in;
   logic [31:0]            out_policy_ff,     out_policy_in;

   logic                   advance;
   logic                   req_take;

   assign advance   = req_full_ff && (!rsp_full_ff || rsp_ready);
   assign req_ready = !req_full_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         my_box_ff           <= 1'b0;
         migrate_limit_ff    <= '0;
         my_subscriber_ff    <= '0;
         expected_version_ff <= tboa_pkg::VERSION_RESET;
      end else if (csr_valid) begin
         unique case (tboa_pkg::csr_index_type'(csr_index))
            tboa_pkg::CSR_MY_BOX:           my_box_ff           <= csr_data[0];
            tboa_pkg::CSR_MIGRATE_LIMIT:    migrate_limit_ff    <= csr_data;
            tboa_pkg::CSR_MY_SUBSCRIBER:    my_subscriber_ff    <= csr_data;
            tboa_pkg::CSR_EXPECTED_VERSION: expected_version_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff <= 1'b0;
      end else if (req_take) begin
         req_full_ff <= 1'b1;
      end else if (advance) begin
         req_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         command_ff    <= tboa_pkg::command_type'(req_command);
         version_ff    <= req_in_version;
         subscriber_ff <= req_in_subscriber;
         epoch_ff      <= req_in_epoch;
         gen_ff        <= req_in_gen;
         owner_wide_ff <= req_in_owner_wide;
         owner_byte_ff <= req_in_owner_byte;
         activation_ff <= req_in_activation;
         stamp_ff      <= req_in_stamp;
         policy_ff     <= req_in_policy;
         event_time_ff <= req_event_time;
      end
   end

   // Decision logic: one request against the current record.
   logic [7:0]          my_owner_code;
   logic [7:0]          partner_code;
   logic [7:0]          upd_owner;
   logic [63:0]         upd_stamp;
   tboa_pkg::mode_type  upd_mode;
   logic                do_claim;
   tboa_pkg::cause_type claim_cause;
   logic                take_update;
   logic [31:0]         misroute_next;

   always_comb begin
      my_owner_code = {7'd0, my_box_ff};
      partner_code  = {7'd0, ~my_box_ff};

      if (tboa_pkg::owner_ok(owner_wide_ff)) begin
         upd_owner = owner_wide_ff[7:0];
      end else if (tboa_pkg::owner_ok({8'd0, owner_byte_ff})) begin
         upd_owner = owner_byte_ff;
      end else begin
         upd_owner = tboa_pkg::OWNER_UNOWNED;
      end
      upd_stamp = (activation_ff != 64'd0) ? activation_ff : stamp_ff;
      upd_mode  = (upd_owner == tboa_pkg::OWNER_UNOWNED) ? tboa_pkg::MODE_UNOWNED
                                                         : tboa_pkg::MODE_REMOTE;
      misroute_next = (misroute_count_ff != '1) ? misroute_count_ff + 32'd1
                                                : misroute_count_ff;

      cur_owner_in      = cur_owner_ff;
      own_mode_in       = own_mode_ff;
      cur_epoch_in      = cur_epoch_ff;
      cur_gen_in        = cur_gen_ff;
      cur_activation_in = cur_activation_ff;
      cur_last_seen_in  = cur_last_seen_ff;
      cur_policy_in     = cur_policy_ff;
      misroute_count_in = misroute_count_ff;

      status_in         = 1'b0;
      verdict_in        = tboa_pkg::VERDICT_NOOP;
      cause_in          = tboa_pkg::CAUSE_INVALID;
      emit_in           = 1'b0;
      out_owner_in      = '0;
      out_gen_in        = '0;
      out_epoch_in      = '0;
      out_activation_in = '0;
      out_policy_in     = '0;

      do_claim    = 1'b0;
      claim_cause = tboa_pkg::CAUSE_CLAIM;
      take_update = 1'b0;

      unique case (command_ff)
         tboa_pkg::CMD_REMOTE_UPDATE: begin
            if (version_ff != expected_version_ff || subscriber_ff != my_subscriber_ff) begin
               status_in = 1'b1;
            end else if (epoch_ff > cur_epoch_ff) begin
               cur_epoch_in = epoch_ff;
               cur_gen_in   = gen_ff;
               take_update  = 1'b1;
               verdict_in   = tboa_pkg::VERDICT_APPLY_REMOTE;
               cause_in     = tboa_pkg::CAUSE_NEWER_EPOCH;
            end else if (epoch_ff < cur_epoch_ff) begin
               verdict_in = tboa_pkg::VERDICT_KEEP_LOCAL;
               cause_in   = tboa_pkg::CAUSE_STALE_EPOCH;
            end else if (gen_ff > cur_gen_ff) begin
               cur_gen_in  = gen_ff;
               take_update = 1'b1;
               verdict_in  = tboa_pkg::VERDICT_APPLY_REMOTE;
               cause_in    = tboa_pkg::CAUSE_HIGHER_GEN;
            end else if (gen_ff < cur_gen_ff) begin
               verdict_in = tboa_pkg::VERDICT_KEEP_LOCAL;
               cause_in   = tboa_pkg::CAUSE_STALE_GEN;
            end else if (upd_owner == cur_owner_ff) begin
               cause_in = tboa_pkg::CAUSE_DUPLICATE;
            end else if (upd_owner < cur_owner_ff) begin
               take_update = 1'b1;
               verdict_in  = tboa_pkg::VERDICT_APPLY_REMOTE;
               cause_in    = tboa_pkg::CAUSE_TIE_WIN;
            end else begin
               verdict_in = tboa_pkg::VERDICT_KEEP_LOCAL;
               cause_in   = tboa_pkg::CAUSE_TIE_KEEP;
            end
         end
         tboa_pkg::CMD_PACKET_EVENT: begin
            if (cur_owner_ff == my_owner_code) begin
               cur_last_seen_in = event_time_ff;
               verdict_in       = tboa_pkg::VERDICT_PROCESS_LOCAL;
               cause_in         = tboa_pkg::CAUSE_HIT;
            end else if (cur_owner_ff == partner_code) begin
               // The count saturates first; passing a nonzero limit restarts it.
               if (migrate_limit_ff != 32'd0 && misroute_next > migrate_limit_ff) begin
                  misroute_count_in = '0;
                  verdict_in        = tboa_pkg::VERDICT_MIGRATE;
                  cause_in          = tboa_pkg::CAUSE_MIGRATE;
               end else begin
                  misroute_count_in = misroute_next;
                  verdict_in        = tboa_pkg::VERDICT_FORWARD;
                  cause_in          = tboa_pkg::CAUSE_MISROUTE;
               end
            end else if (cur_owner_ff == tboa_pkg::OWNER_UNOWNED) begin
               do_claim    = 1'b1;
               claim_cause = tboa_pkg::CAUSE_UNOWNED_CLAIM;
            end else begin
               verdict_in = tboa_pkg::VERDICT_FORWARD;
               cause_in   = tboa_pkg::CAUSE_MISROUTE;
            end
         end
         tboa_pkg::CMD_LOCAL_CLAIM: begin
            do_claim = 1'b1;
         end
         default: begin
            status_in = 1'b1;
         end
      endcase

      if (take_update) begin
         cur_owner_in      = upd_owner;
         cur_activation_in = upd_stamp;
         cur_last_seen_in  = upd_stamp;
         cur_policy_in     = policy_ff;
         own_mode_in       = upd_mode;
      end

      if (do_claim) begin
         if (cur_owner_ff == my_owner_code && own_mode_ff == tboa_pkg::MODE_LOCAL) begin
            // Already ours: only refresh the last-seen time.
            cur_last_seen_in = event_time_ff;
            cause_in         = tboa_pkg::CAUSE_REFRESH;
         end else begin
            cur_owner_in      = my_owner_code;
            cur_gen_in        = cur_gen_ff + 32'd1;
            cur_activation_in = event_time_ff;
            cur_last_seen_in  = event_time_ff;
            misroute_count_in = '0;
            own_mode_in       = tboa_pkg::MODE_LOCAL;
            verdict_in        = tboa_pkg::VERDICT_EMIT_UPDATE;
            cause_in          = claim_cause;
            emit_in           = 1'b1;
            out_owner_in      = my_owner_code;
            out_gen_in        = cur_gen_ff + 32'd1;
            out_epoch_in      = cur_epoch_ff;
            out_activation_in = event_time_ff;
            out_policy_in     = cur_policy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_owner_ff      <= tboa_pkg::OWNER_UNOWNED;
         own_mode_ff       <= tboa_pkg::MODE_UNOWNED;
         cur_epoch_ff      <= '0;
         cur_gen_ff        <= '0;
         cur_activation_ff <= '0;
         cur_last_seen_ff  <= '0;
         cur_policy_ff     <= '0;
         misroute_count_ff <= '0;
      end else if (advance) begin
         cur_owner_ff      <= cur_owner_in;
         own_mode_ff       <= own_mode_in;
         cur_epoch_ff      <= cur_epoch_in;
         cur_gen_ff        <= cur_gen_in;
         cur_activation_ff <= cur_activation_in;
         cur_last_seen_ff  <= cur_last_seen_in;
         cur_policy_ff     <= cur_policy_in;
         misroute_count_ff <= misroute_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_full_ff <= 1'b0;
      end else if (advance) begin
         rsp_full_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff         <= status_in;
         verdict_ff        <= verdict_in;
         cause_ff          <= cause_in;
         emit_ff           <= emit_in;
         out_owner_ff      <= out_owner_in;
         out_gen_ff        <= out_gen_in;
         out_epoch_ff      <= out_epoch_in;
         out_activation_ff <= out_activation_in;
         out_policy_ff     <= out_policy_in;
      end
   end

   assign rsp_valid          = rsp_full_ff;
   assign rsp_status_code    = status_ff;
   assign rsp_verdict        = verdict_ff;
   assign rsp_cause          = cause_ff;
   assign rsp_emit_valid     = emit_ff;
   assign rsp_out_owner      = out_owner_ff;
   assign rsp_out_gen        = out_gen_ff;
   assign rsp_out_epoch      = out_epoch_ff;
   assign rsp_out_activation = out_activation_ff;
   assign rsp_out_policy     = out_policy_ff;

endmodule
